// ===== sv/fdc_pkg.sv =====
package fdc_pkg;

	localparam int CNT_W   = 7;
	localparam int BYTE_W  = 8;
	localparam int CRC_W   = 32;
	localparam int CFG_A_W = 2;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam logic [CNT_W-1:0] HDR_LAST = 7'd6;
	localparam logic [CNT_W-1:0] CRC_LAST = 7'd3;

	localparam logic [CFG_A_W-1:0] CFG_SYNC_FIRST    = 2'd0;
	localparam logic [CFG_A_W-1:0] CFG_SYNC_SECOND   = 2'd1;
	localparam logic [CFG_A_W-1:0] CFG_PAYLOAD_LIMIT = 2'd2;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST    = 8'd170;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST   = 8'd85;
	localparam logic [CNT_W-1:0]  PAYLOAD_LIMIT_RST = 7'd64;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_context;
		logic [BYTE_W-1:0] frame_type;
		logic [BYTE_W-1:0] frame_sequence;
		logic [CNT_W-1:0]  payload_length;
	} rp_start_t;

	// Reflected CRC-32 update over one byte, one bit per step.
	function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < BYTE_W; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== sv/fdc_if.sv =====
interface fdc_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] rx_byte;
	modport source(output valid, op, rx_byte, input ready);
	modport sink(input valid, op, rx_byte, output ready);
endinterface

interface fdc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_context;
	logic [7:0] frame_type;
	logic [7:0] frame_sequence;
	logic [6:0] payload_length;
	logic [7:0] payload_byte;
	logic       byte_valid;
	logic       last;
	modport source(output valid, frame_context, frame_type, frame_sequence, payload_length,
		payload_byte, byte_valid, last, input ready);
	modport sink(input valid, frame_context, frame_type, frame_sequence, payload_length,
		payload_byte, byte_valid, last, output ready);
endinterface

interface fdc_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] addr;
	logic [7:0] data;
	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

// ===== sv/fdc_replay.sv =====
module fdc_replay #(
	parameter int PAYLOAD_DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [fdc_pkg::CNT_W-1:0] wr_addr,
	input  logic [7:0]                wr_data,
	input  logic                      start,
	input  fdc_pkg::rp_start_t        start_info,
	output logic                      busy,
	fdc_out_if.source                 dout
);
	import fdc_pkg::*;

	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

	logic [BYTE_W-1:0] mem [PAYLOAD_DEPTH];

	rp_start_t         info_q;
	logic              active_q;
	logic [CNT_W-1:0]  rp_cnt_q;
	logic [CNT_W-1:0]  rp_next;
	logic [CNT_W-1:0]  n_items;
	logic              issue_last;
	logic              rd_en;
	logic              move;

	logic [BYTE_W-1:0] rd_data_s1;
	logic              vld_s1;
	logic              last_s1;
	logic              bv_s1;

	logic              out_vld_q;
	rp_start_t         out_info_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_bv_q;
	logic              out_last_q;

	// An empty frame still yields one header-only result.
	assign n_items    = (info_q.payload_length == '0) ? CNT_W'(1) : info_q.payload_length;
	assign rp_next    = rp_cnt_q + CNT_W'(1);
	assign issue_last = (rp_next == n_items);
	assign move       = vld_s1 && (!out_vld_q || dout.ready);
	assign rd_en      = active_q && (!vld_s1 || move);
	assign busy       = active_q || vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr[AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rp_cnt_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			info_q <= start_info;
		end
		if (rd_en) begin
			last_s1 <= issue_last;
			bv_s1   <= (info_q.payload_length != '0);
		end
		if (move) begin
			out_info_q <= info_q;
			out_byte_q <= bv_s1 ? rd_data_s1 : '0;
			out_bv_q   <= bv_s1;
			out_last_q <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			rp_cnt_q  <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (start) begin
				active_q <= 1'b1;
				rp_cnt_q <= '0;
			end else if (rd_en) begin
				rp_cnt_q <= rp_next;
				if (issue_last) begin
					active_q <= 1'b0;
				end
			end
			if (rd_en) begin
				vld_s1 <= 1'b1;
			end else if (move) begin
				vld_s1 <= 1'b0;
			end
			if (move) begin
				out_vld_q <= 1'b1;
			end else if (dout.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign dout.valid          = out_vld_q;
	assign dout.frame_context  = out_info_q.frame_context;
	assign dout.frame_type     = out_info_q.frame_type;
	assign dout.frame_sequence = out_info_q.frame_sequence;
	assign dout.payload_length = out_info_q.payload_length;
	assign dout.payload_byte   = out_byte_q;
	assign dout.byte_valid     = out_bv_q;
	assign dout.last           = out_last_q;

endmodule

// ===== sv/frame_deframer_crc32_check_unit.sv =====
// Parsing takes one received byte per cycle while the replay is not busy; the CRC-32 of a byte
// is folded in the same cycle. After the last CRC byte of a good frame the payload memory
// replays max(len, 1) results at one per cycle while the output is not stalled, limited by
// its single registered read port. Input requests stall from the final CRC byte until the
// last read has left the read stage. Reset restores the sync hunt and the configuration
// defaults but not the payload memory; each valid byte a replay outputs is written first.
module frame_deframer_crc32_check_unit #(
	parameter int PAYLOAD_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	fdc_in_if.sink    din,
	fdc_out_if.source dout,
	fdc_cfg_if.sink   cfg
);
	import fdc_pkg::*;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PAYLOAD_DEPTH);

	typedef enum logic [4:0] {
		PH_HUNT1   = 5'b00001,
		PH_HUNT2   = 5'b00010,
		PH_HEADER  = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_CHECK   = 5'b10000
	} phase_t;

	logic [BYTE_W-1:0] sync_first_q;
	logic [BYTE_W-1:0] sync_second_q;
	logic [CNT_W-1:0]  payload_limit_q;

	phase_t            phase_q, phase_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CRC_W-1:0]  crc_q, crc_d;
	logic [CRC_W-1:0]  rcv_q, rcv_d;
	logic [CNT_W-1:0]  len_q, len_d;
	logic [BYTE_W-1:0] hdr_q [HDR_LAST];
	logic              hdr_we;

	logic              acc;
	logic              rp_busy;
	logic              start;
	rp_start_t         start_info;
	logic              mem_we;
	logic [CNT_W-1:0]  limit;
	logic [CRC_W-1:0]  crc_next;
	logic [CRC_W-1:0]  len32;
	logic              len_over;
	logic [CNT_W-1:0]  cnt_inc;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q    <= SYNC_FIRST_RST;
			sync_second_q   <= SYNC_SECOND_RST;
			payload_limit_q <= PAYLOAD_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				CFG_SYNC_FIRST:    sync_first_q    <= cfg.data;
				CFG_SYNC_SECOND:   sync_second_q   <= cfg.data;
				CFG_PAYLOAD_LIMIT: payload_limit_q <= cfg.data[CNT_W-1:0];
				default:           ;
			endcase
		end
	end

	assign din.ready = !rp_busy;
	assign acc       = din.valid && din.ready;
	assign limit     = (payload_limit_q > DEPTH_C) ? DEPTH_C : payload_limit_q;
	assign crc_next  = crc32_byte(crc_q, din.rx_byte);
	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign len32     = {din.rx_byte, hdr_q[5], hdr_q[4], hdr_q[3]};
	// The full 32-bit length takes part in the limit check.
	assign len_over  = (|len32[CRC_W-1:CNT_W]) || (len32[CNT_W-1:0] > limit);

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		crc_d   = crc_q;
		rcv_d   = rcv_q;
		len_d   = len_q;
		hdr_we  = 1'b0;
		mem_we  = 1'b0;
		start   = 1'b0;
		if (acc) begin
			if (din.op) begin
				phase_d = PH_HUNT1;
				cnt_d   = '0;
				crc_d   = CRC_INIT;
			end else begin
				unique case (phase_q)
					PH_HUNT2: begin
						if (din.rx_byte == sync_second_q) begin
							phase_d = PH_HEADER;
							cnt_d   = '0;
							crc_d   = CRC_INIT;
						end else if (din.rx_byte != sync_first_q) begin
							phase_d = PH_HUNT1;
						end
					end
					PH_HEADER: begin
						hdr_we = (cnt_q != HDR_LAST);
						crc_d  = crc_next;
						cnt_d  = cnt_inc;
						if (cnt_q == HDR_LAST) begin
							cnt_d = '0;
							rcv_d = '0;
							len_d = len32[CNT_W-1:0];
							if (len_over) begin
								phase_d = PH_HUNT1;
								crc_d   = CRC_INIT;
							end else if (len32[CNT_W-1:0] != '0) begin
								phase_d = PH_PAYLOAD;
							end else begin
								phase_d = PH_CHECK;
							end
						end
					end
					PH_PAYLOAD: begin
						mem_we = 1'b1;
						crc_d  = crc_next;
						cnt_d  = cnt_inc;
						if (cnt_inc >= len_q) begin
							phase_d = PH_CHECK;
							cnt_d   = '0;
						end
					end
					PH_CHECK: begin
						// The received CRC arrives least significant byte first.
						rcv_d = {din.rx_byte, rcv_q[CRC_W-1:BYTE_W]};
						cnt_d = cnt_inc;
						if (cnt_q == CRC_LAST) begin
							start   = ((crc_q ^ CRC_INIT) == rcv_d);
							phase_d = PH_HUNT1;
							cnt_d   = '0;
							crc_d   = CRC_INIT;
						end
					end
					default: begin
						phase_d = (din.rx_byte == sync_first_q) ? PH_HUNT2 : PH_HUNT1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			cnt_q   <= '0;
			crc_q   <= CRC_INIT;
			rcv_q   <= '0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			crc_q   <= crc_d;
			rcv_q   <= rcv_d;
		end
	end

	always_ff @(posedge clk) begin
		len_q <= len_d;
		if (hdr_we) begin
			hdr_q[cnt_q[2:0]] <= din.rx_byte;
		end
	end

	assign start_info.frame_context  = hdr_q[0];
	assign start_info.frame_type     = hdr_q[1];
	assign start_info.frame_sequence = hdr_q[2];
	assign start_info.payload_length = len_q;

	fdc_replay #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH)
	) u_replay (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (mem_we),
		.wr_addr   (cnt_q),
		.wr_data   (din.rx_byte),
		.start     (start),
		.start_info(start_info),
		.busy      (rp_busy),
		.dout      (dout)
	);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> rp_busy)
		else $error("replay did not start after a good CRC");

	a_payload_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (cnt_q < len_q && len_q <= DEPTH_C))
		else $error("payload count out of range");

	a_header_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEADER) |-> (cnt_q <= HDR_LAST))
		else $error("header count out of range");

endmodule
